[rtl/drrip_deadblock_replacement_top_defines.svh]
// Assertion macros shared by the replacement engine RTL.
// No dependencies; taken in by the top level through `include.
`ifndef DRRIP_DEADBLOCK_REPLACEMENT_TOP_DEFINES_SVH
`define DRRIP_DEADBLOCK_REPLACEMENT_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low.
`define DRRIP_DB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DRRIP_DB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DRRIP_DB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define DRRIP_DB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[rtl/drrip_db_pkg.sv]
// Shared constants, codes and controller/datapath types for the replacement engine.
// No dependencies.
`default_nettype none

package drrip_db_pkg;

  // Geometry
  localparam int NUM_SETS      = 2048;
  localparam int NUM_WAYS      = 16;
  localparam int LEADER_COUNT  = 32;
  localparam int SELECTOR_BITS = 10;

  localparam int SET_W = $clog2(NUM_SETS);
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int CNT_W = SET_W + 1;
  localparam int ROW_W = 2 * NUM_WAYS;

  // Word field widths
  localparam int IN_CMD_W  = 2;
  localparam int IN_SET_W  = 11;
  localparam int IN_WAY_W  = 4;
  localparam int IN_DRAW_W = 5;
  localparam int OUT_WAY_W = 4;
  localparam int OUT_INS_W = 2;
  localparam int OUT_SEL_W = 10;

  localparam int BR_BASE = NUM_SETS - LEADER_COUNT;

  localparam logic [1:0] RRPV_MAX  = 2'd3;
  localparam logic [1:0] RRPV_LONG = 2'd2;
  localparam logic [1:0] DEAD_MAX  = 2'd3;

  localparam logic [SELECTOR_BITS-1:0] PSEL_MID =
    SELECTOR_BITS'(1 << (SELECTOR_BITS - 1));
  localparam logic [SELECTOR_BITS-1:0] PSEL_TOP =
    SELECTOR_BITS'((1 << SELECTOR_BITS) - 1);

  typedef enum logic [1:0] {
    CMD_VICTIM = 2'd0,
    CMD_HIT    = 2'd1,
    CMD_FILL   = 2'd2,
    CMD_DECAY  = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DECAY,
    ST_RESP
  } ctrl_state_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLEAR,
    WR_EXEC,
    WR_DECAY
  } wr_kind_t;

  typedef struct packed {
    logic             capture;    // latch input word, read its set row
    logic             sweep_rd;   // read row at sweep_addr
    logic [SET_W-1:0] sweep_addr;
    wr_kind_t         wr_kind;
    logic             out_load;   // load result register
  } dp_cmd_t;

  typedef struct packed {
    logic is_decay;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/drrip_db_in_if.sv]
// Input channel of the replacement engine: valid/ready plus command word.
// Depends on drrip_db_pkg for field widths.
`default_nettype none

interface drrip_db_in_if import drrip_db_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [IN_CMD_W-1:0]  command;
  logic [IN_SET_W-1:0]  set_index;
  logic [IN_WAY_W-1:0]  way_index;
  logic [IN_DRAW_W-1:0] random_draw;

  modport source (output valid, command, set_index, way_index, random_draw,
                  input ready);
  modport sink   (input valid, command, set_index, way_index, random_draw,
                  output ready);
endinterface

`default_nettype wire

[rtl/drrip_db_out_if.sv]
// Result channel of the replacement engine: valid/ready plus result word.
// Depends on drrip_db_pkg for field widths.
`default_nettype none

interface drrip_db_out_if import drrip_db_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [OUT_WAY_W-1:0] victim_way;
  logic [OUT_INS_W-1:0] inserted_rrpv;
  logic [OUT_SEL_W-1:0] selector_value;

  modport source (output valid, victim_way, inserted_rrpv, selector_value,
                  input ready);
  modport sink   (input valid, victim_way, inserted_rrpv, selector_value,
                  output ready);
endinterface

`default_nettype wire

[rtl/drrip_db_datapath.sv]
// Datapath: RRPV and dead-counter row memories, PSEL, row update logic, result register.
// Depends on drrip_db_pkg; driven by drrip_db_ctrl through dp_cmd_t.
`default_nettype none

module drrip_db_datapath import drrip_db_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dp_cmd_t              cmd,
  output dp_status_t                status,
  input  wire logic [IN_CMD_W-1:0]  in_command,
  input  wire logic [IN_SET_W-1:0]  in_set_index,
  input  wire logic [IN_WAY_W-1:0]  in_way_index,
  input  wire logic [IN_DRAW_W-1:0] in_random_draw,
  output logic      [OUT_WAY_W-1:0] out_victim_way,
  output logic      [OUT_INS_W-1:0] out_inserted_rrpv,
  output logic      [OUT_SEL_W-1:0] out_selector_value
);

  logic [ROW_W-1:0] rrpv_mem [NUM_SETS];
  logic [ROW_W-1:0] dead_mem [NUM_SETS];

  command_t             cmd_r;
  logic [WAY_W-1:0]     way_r;
  logic [IN_DRAW_W-1:0] draw_r;
  logic [SET_W-1:0]     rd_addr_r;
  logic [ROW_W-1:0]     rrpv_rd_r;
  logic [ROW_W-1:0]     dead_rd_r;
  logic [SELECTOR_BITS-1:0] psel_r, psel_nxt;

  logic [SET_W-1:0] rd_addr, wr_addr;
  logic             rd_en, rrpv_we, dead_we;
  logic [ROW_W-1:0] rrpv_wd, dead_wd;

  logic [1:0] rr_way [NUM_WAYS];
  logic [1:0] dd_way [NUM_WAYS];
  logic       top_hi, top_lo, found;
  logic [1:0] top, age;
  logic [WAY_W-1:0] victim_pos;
  logic [1:0] sel_dead, fill_ins;
  logic       lead_sr, lead_br, use_br;
  logic [SELECTOR_BITS-1:0] psel_up, psel_hit;
  logic [ROW_W-1:0] rrpv_new_row, dead_new_row, dead_dec_row;

  // Row read, registered
  assign rd_addr = cmd.capture ? in_set_index[SET_W-1:0] : cmd.sweep_addr;
  assign rd_en   = cmd.capture | cmd.sweep_rd;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rrpv_rd_r <= rrpv_mem[rd_addr];
      dead_rd_r <= dead_mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= command_t'(in_command);
      way_r  <= in_way_index[WAY_W-1:0];
      draw_r <= in_random_draw;
    end
  end

  // Row unpack and victim search over the registered row
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      rr_way[w] = rrpv_rd_r[2*w +: 2];
      dd_way[w] = dead_rd_r[2*w +: 2];
    end
  end

  always_comb begin
    top_hi = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) top_hi = top_hi | rr_way[w][1];
    top_lo = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++)
      top_lo = top_lo | (rr_way[w][0] & (rr_way[w][1] == top_hi));
  end

  assign top = {top_hi, top_lo};
  assign age = RRPV_MAX - top;

  always_comb begin
    victim_pos = '0;
    found      = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!found && rr_way[w] == top) begin
        victim_pos = WAY_W'(w);
        found      = 1'b1;
      end
    end
  end

  // Insertion policy
  assign sel_dead = dd_way[way_r];
  assign lead_sr  = rd_addr_r < SET_W'(LEADER_COUNT);
  assign lead_br  = rd_addr_r >= SET_W'(BR_BASE);
  assign use_br   = lead_sr ? 1'b0 : (lead_br ? 1'b1 : (psel_r < PSEL_MID));

  always_comb begin
    if (sel_dead == DEAD_MAX)
      fill_ins = RRPV_MAX;
    else if (use_br && draw_r != '0)
      fill_ins = RRPV_MAX;
    else
      fill_ins = RRPV_LONG;
  end

  // Updated rows
  always_comb begin
    rrpv_new_row = rrpv_rd_r;
    dead_new_row = dead_rd_r;
    for (int w = 0; w < NUM_WAYS; w++) begin
      dead_dec_row[2*w +: 2] = (dd_way[w] != 2'd0) ? dd_way[w] - 2'd1 : 2'd0;
      case (cmd_r)
        CMD_VICTIM: rrpv_new_row[2*w +: 2] = rr_way[w] + age;
        CMD_HIT: begin
          if (WAY_W'(w) == way_r) begin
            rrpv_new_row[2*w +: 2] = 2'd0;
            dead_new_row[2*w +: 2] = (dd_way[w] != 2'd0) ? dd_way[w] - 2'd1 : 2'd0;
          end
        end
        CMD_FILL: begin
          if (WAY_W'(w) == way_r) begin
            rrpv_new_row[2*w +: 2] = fill_ins;
            dead_new_row[2*w +: 2] = (dd_way[w] != DEAD_MAX) ? dd_way[w] + 2'd1 : DEAD_MAX;
          end
        end
        default: ;
      endcase
    end
  end

  // Row write
  assign wr_addr = (cmd.wr_kind == WR_CLEAR) ? cmd.sweep_addr : rd_addr_r;
  assign rrpv_we = (cmd.wr_kind == WR_CLEAR) || (cmd.wr_kind == WR_EXEC);
  assign dead_we = (cmd.wr_kind != WR_NONE);
  assign rrpv_wd = (cmd.wr_kind == WR_CLEAR) ? {ROW_W{1'b1}} : rrpv_new_row;

  always_comb begin
    case (cmd.wr_kind)
      WR_CLEAR: dead_wd = '0;
      WR_DECAY: dead_wd = dead_dec_row;
      default:  dead_wd = dead_new_row;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rrpv_we) rrpv_mem[wr_addr] <= rrpv_wd;
  end

  always_ff @(posedge clk) begin
    if (dead_we) dead_mem[wr_addr] <= dead_wd;
  end

  // Set-dueling selector: SR leader hit counts up, BR leader hit down
  assign psel_up  = (lead_sr && psel_r != PSEL_TOP) ? psel_r + 1'b1 : psel_r;
  assign psel_hit = (lead_br && psel_up != '0) ? psel_up - 1'b1 : psel_up;
  assign psel_nxt = (cmd.wr_kind == WR_EXEC && cmd_r == CMD_HIT) ? psel_hit : psel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) psel_r <= PSEL_MID;
    else        psel_r <= psel_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_victim_way     <= (cmd_r == CMD_VICTIM) ? OUT_WAY_W'(victim_pos) : '0;
      out_inserted_rrpv  <= (cmd_r == CMD_FILL) ? fill_ins : 2'd0;
      out_selector_value <= psel_nxt[OUT_SEL_W-1:0];
    end
  end

  assign status.is_decay = (cmd_r == CMD_DECAY);

endmodule

`default_nettype wire

[rtl/drrip_db_ctrl.sv]
// Controller: clearing pass, command sequencing, decay sweep and result handshake.
// Depends on drrip_db_pkg; drives drrip_db_datapath through dp_cmd_t.
`default_nettype none

module drrip_db_ctrl import drrip_db_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free, clear_last, sweep_end;

  assign slot_free  = !out_valid_r || out_ready;
  assign clear_last = (cnt_r == CNT_W'(NUM_SETS - 1));
  assign sweep_end  = (cnt_r == CNT_W'(NUM_SETS));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clear_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (status.is_decay) state_nxt = ST_DECAY;
        else if (slot_free)  state_nxt = ST_IDLE;
      end
      ST_DECAY: if (sweep_end) state_nxt = ST_RESP;
      ST_RESP:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // Row counter for clearing pass and decay sweep
  always_comb begin
    case (state_r)
      ST_CLEAR: cnt_nxt = clear_last ? '0 : cnt_r + 1'b1;
      ST_DECAY: cnt_nxt = cnt_r + 1'b1;
      default:  cnt_nxt = '0;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd.capture    = 1'b0;
    cmd.sweep_rd   = 1'b0;
    cmd.sweep_addr = cnt_r[SET_W-1:0];
    cmd.wr_kind    = WR_NONE;
    cmd.out_load   = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.wr_kind = WR_CLEAR;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        if (!status.is_decay && slot_free) begin
          cmd.wr_kind  = WR_EXEC;
          cmd.out_load = 1'b1;
        end
      end
      ST_DECAY: begin
        cmd.sweep_rd = !sweep_end;
        if (cnt_r != '0) cmd.wr_kind = WR_DECAY;
      end
      ST_RESP: cmd.out_load = slot_free;
      default: ;
    endcase
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/drrip_deadblock_replacement_top.sv]
// Replacement engine for a 2048-set, 16-way last-level cache (DRRIP with
// dead-block prediction). After reset the engine runs a clearing pass over
// its row memories (all RRPVs to 3, all dead counters to 0) and takes no
// word until that pass ends. Victim, hit and fill commands then first read
// the set's RRPV and dead-counter rows from their single-port-read memories
// into registers, then update and write the rows back and load the result
// register. A decay command sweeps every row of the dead-counter memory,
// one row read and one written per cycle. The result register lets a
// new word be taken while the last result still waits; the engine stalls
// before writing back if that register is still full.
//
// Depends on drrip_db_pkg, the channel interfaces, drrip_db_ctrl and
// drrip_db_datapath; assertion macros from the defines header.
`default_nettype none
`include "drrip_deadblock_replacement_top_defines.svh"

module drrip_deadblock_replacement_top import drrip_db_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  drrip_db_in_if.sink     in_chan,
  drrip_db_out_if.source  out_chan
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic       in_ready, out_valid;

  // Sequencer: clearing pass, per-word sequencing, decay sweep, output valid
  drrip_db_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  // Row memories, PSEL and result word
  drrip_db_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (dp_cmd),
    .status             (dp_status),
    .in_command         (in_chan.command),
    .in_set_index       (in_chan.set_index),
    .in_way_index       (in_chan.way_index),
    .in_random_draw     (in_chan.random_draw),
    .out_victim_way     (out_chan.victim_way),
    .out_inserted_rrpv  (out_chan.inserted_rrpv),
    .out_selector_value (out_chan.selector_value)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

  // No word is taken during the clearing pass
  `DRRIP_DB_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n,
    dp_cmd.wr_kind == WR_CLEAR, !in_ready, "word accepted during clearing pass")

  // One word at a time: busy in the cycle after an accept
  `DRRIP_DB_ASSERT_NXT(a_busy_after_accept, clk, rst_n,
    in_chan.valid && in_ready, !in_ready, "second word accepted back to back")

  // A result only appears after the datapath loaded it
  `DRRIP_DB_ASSERT_IMP(a_valid_from_load, clk, rst_n,
    $rose(out_valid), $past(dp_cmd.out_load), "result valid without a load")

  // Write-back never overruns a result still waiting
  `DRRIP_DB_ASSERT_IMP(a_load_slot_free, clk, rst_n,
    dp_cmd.out_load, !out_valid || out_chan.ready, "result register overrun")

endmodule

`default_nettype wire

[dv/drrip_db_tb_pkg.sv]
// Scoreboard for the DRRIP dead-block replacement engine: its own model of
// the RRPV, dead-counter and PSEL state, and the queue of expected results.
// Depends on drrip_db_pkg for geometry, codes and field widths.
`timescale 1ns / 1ps

package drrip_db_tb_pkg;
  import drrip_db_pkg::*;

  typedef struct packed {
    logic [OUT_WAY_W-1:0] victim_way;
    logic [OUT_INS_W-1:0] inserted_rrpv;
    logic [OUT_SEL_W-1:0] selector_value;
  } outcome_t;

  class rrip_scoreboard;
    logic [1:0]               rrpv_store [NUM_SETS][NUM_WAYS];
    logic [1:0]               dead_store [NUM_SETS][NUM_WAYS];
    logic [SELECTOR_BITS-1:0] psel;
    logic [SELECTOR_BITS-1:0] psel_lo;
    logic [SELECTOR_BITS-1:0] psel_hi;
    logic [WAY_W-1:0]         last_victim;
    outcome_t                 pending_outcomes [$];
    int unsigned              mismatches;
    int unsigned              checked;
    int unsigned              words_by_cmd [4];

    function new();
      for (int s = 0; s < NUM_SETS; s++) begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          rrpv_store[s][w] = RRPV_MAX;
          dead_store[s][w] = 2'd0;
        end
      end
      psel        = PSEL_MID;
      psel_lo     = PSEL_MID;
      psel_hi     = PSEL_MID;
      last_victim = '0;
      mismatches  = 0;
      checked     = 0;
      foreach (words_by_cmd[i]) words_by_cmd[i] = 0;
    endfunction

    // Advances the model by one command and returns the result it yields.
    function outcome_t apply_command(command_t cmd, logic [IN_SET_W-1:0] set_in,
                                     logic [IN_WAY_W-1:0] way_in,
                                     logic [IN_DRAW_W-1:0] draw);
      int         s;
      int         w;
      int         top;
      int         pos;
      bit         sr_lead;
      bit         br_lead;
      bit         use_br;
      logic [1:0] ins;
      outcome_t   res;
      s       = int'(set_in) % NUM_SETS;
      w       = int'(way_in) % NUM_WAYS;
      sr_lead = s < LEADER_COUNT;
      br_lead = s >= BR_BASE;
      res     = '0;
      case (cmd)
        CMD_VICTIM: begin
          top = 0;
          pos = 0;
          for (int i = 0; i < NUM_WAYS; i++) begin
            if (rrpv_store[s][i] > top) begin
              top = int'(rrpv_store[s][i]);
              pos = i;
            end
          end
          // no line at distant re-reference: age the whole set until one is
          if (top < RRPV_MAX) begin
            for (int i = 0; i < NUM_WAYS; i++)
              rrpv_store[s][i] = 2'(rrpv_store[s][i] + (RRPV_MAX - top));
          end
          res.victim_way = OUT_WAY_W'(pos);
          last_victim    = WAY_W'(pos);
        end
        CMD_HIT: begin
          rrpv_store[s][w] = 2'd0;
          if (dead_store[s][w] > 0) dead_store[s][w] = dead_store[s][w] - 2'd1;
          if (sr_lead && psel < PSEL_TOP) psel = psel + 1'b1;
          if (br_lead && psel > 0) psel = psel - 1'b1;
        end
        CMD_FILL: begin
          if (sr_lead) use_br = 1'b0;
          else if (br_lead) use_br = 1'b1;
          else use_br = psel < PSEL_MID;
          if (dead_store[s][w] == DEAD_MAX) ins = RRPV_MAX;
          else if (use_br) ins = (draw == 0) ? RRPV_LONG : RRPV_MAX;
          else ins = RRPV_LONG;
          rrpv_store[s][w] = ins;
          if (dead_store[s][w] < DEAD_MAX) dead_store[s][w] = dead_store[s][w] + 2'd1;
          res.inserted_rrpv = ins;
        end
        default: begin
          for (int a = 0; a < NUM_SETS; a++) begin
            for (int b = 0; b < NUM_WAYS; b++) begin
              if (dead_store[a][b] > 0) dead_store[a][b] = dead_store[a][b] - 2'd1;
            end
          end
        end
      endcase
      res.selector_value = OUT_SEL_W'(psel);
      if (psel < psel_lo) psel_lo = psel;
      if (psel > psel_hi) psel_hi = psel;
      return res;
    endfunction

    function void note_command(command_t cmd, logic [IN_SET_W-1:0] set_in,
                               logic [IN_WAY_W-1:0] way_in,
                               logic [IN_DRAW_W-1:0] draw);
      words_by_cmd[cmd]++;
      pending_outcomes.push_back(apply_command(cmd, set_in, way_in, draw));
    endfunction

    function void compare_field(string name, logic [15:0] expd, logic [15:0] got);
      if (got !== expd) begin
        $error("%s: expected %0d, got %0d", name, expd, got);
        mismatches++;
      end
    endfunction

    function void check_outcome(logic [OUT_WAY_W-1:0] victim_way,
                                logic [OUT_INS_W-1:0] inserted_rrpv,
                                logic [OUT_SEL_W-1:0] selector_value);
      outcome_t exp_res;
      if (pending_outcomes.size() == 0) begin
        $error("result word with no command outstanding: victim_way %0d rrpv %0d sel %0d",
               victim_way, inserted_rrpv, selector_value);
        mismatches++;
        return;
      end
      exp_res = pending_outcomes.pop_front();
      checked++;
      compare_field("victim_way", 16'(exp_res.victim_way), 16'(victim_way));
      compare_field("inserted_rrpv", 16'(exp_res.inserted_rrpv), 16'(inserted_rrpv));
      compare_field("selector_value", 16'(exp_res.selector_value), 16'(selector_value));
    endfunction
  endclass

endpackage

[dv/drrip_deadblock_replacement_top_tb.sv]
// Self-checking bench for the DRRIP dead-block replacement engine: directed
// corner words, then random miss/hit/fill/decay traffic under four idle/stall mixes.
// Depends on drrip_db_pkg, the channel interfaces, drrip_db_tb_pkg and the RTL top.
`timescale 1ns / 1ps

module drrip_deadblock_replacement_top_tb;
  import drrip_db_pkg::*;
  import drrip_db_tb_pkg::*;

  localparam int      CLK_PERIOD     = 20;
  localparam int      RESET_CYCLES   = 6;
  localparam int      WORDS_PER_MIX  = 125;   // four mixes, about 500 words
  localparam int      DRAIN_CYCLES   = 64;
  // Sized for about ten times the slowest plausible run (clearing pass, a few
  // dozen decay sweeps, heavy idling).
  localparam longint  TIMEOUT_NS     = 64'd20_000_000;
  localparam int      LAST_SET       = NUM_SETS - 1;
  localparam int      LAST_WAY       = NUM_WAYS - 1;
  localparam int      MAX_DRAW       = (1 << IN_DRAW_W) - 1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  drrip_db_in_if  in_if ();
  drrip_db_out_if out_if ();

  drrip_deadblock_replacement_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  rrip_scoreboard        sb;
  int                    src_idle_pct   = 0;
  int                    sink_stall_pct = 0;
  int                    words_sent     = 0;
  logic [IN_SET_W-1:0]   set_pool [8];

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Result side: every value is read as it stood just before the edge, then
  // ready is redrawn for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      sb.check_outcome(out_if.victim_way, out_if.inserted_rrpv, out_if.selector_value);
    end
    out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Offers one command word, after any random idle gap, and holds it until
  // the engine takes it. The model is advanced at the accepting edge, so
  // sb.last_victim is valid straight after a victim word returns.
  task automatic send_word(command_t cmd, logic [IN_SET_W-1:0] set_i,
                           logic [IN_WAY_W-1:0] way_i, logic [IN_DRAW_W-1:0] draw);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= cmd;
    in_if.set_index   <= set_i;
    in_if.way_index   <= way_i;
    in_if.random_draw <= draw;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_command(cmd, set_i, way_i, draw);
    words_sent++;
  endtask

  // Half the draws are zero so that BRRIP near insertion is common.
  function automatic logic [IN_DRAW_W-1:0] pick_draw();
    if ($urandom_range(1) == 0) return '0;
    return IN_DRAW_W'($urandom_range(MAX_DRAW));
  endfunction

  // A cache miss as the host would issue it: ask for a victim, then fill
  // exactly that way of the same set.
  task automatic send_miss(logic [IN_SET_W-1:0] set_i);
    send_word(CMD_VICTIM, set_i, IN_WAY_W'($urandom_range(LAST_WAY)), pick_draw());
    send_word(CMD_FILL, set_i, sb.last_victim, pick_draw());
  endtask

  // One random step of traffic. Most of it lands on a small pool of sets so
  // that rows fill up, age and saturate their dead counters; hits are steered
  // to one kind of leader per mix so PSEL swings either side of its midpoint.
  task automatic random_item(bit favour_br);
    int                  pick;
    logic [IN_SET_W-1:0] set_i;
    pick  = $urandom_range(99);
    set_i = set_pool[3'($urandom_range(7))];
    if (pick < 55) begin
      send_miss(set_i);
    end else if (pick < 78) begin
      if ($urandom_range(99) < 70) begin
        if (favour_br) set_i = $urandom_range(1) ? IN_SET_W'(LAST_SET) : IN_SET_W'(BR_BASE);
        else set_i = $urandom_range(1) ? IN_SET_W'(0) : IN_SET_W'(LEADER_COUNT - 1);
      end
      send_word(CMD_HIT, set_i, IN_WAY_W'($urandom_range(LAST_WAY)), pick_draw());
    end else if (pick < 88) begin
      send_word(CMD_FILL, set_i, IN_WAY_W'($urandom_range(LAST_WAY)), pick_draw());
    end else if (pick < 93) begin
      send_word(CMD_VICTIM, set_i, IN_WAY_W'($urandom_range(LAST_WAY)), pick_draw());
    end else if (pick < 97) begin
      // noise: any set, any way, any draw
      send_word(command_t'($urandom_range(2)), IN_SET_W'($urandom_range(LAST_SET)),
                IN_WAY_W'($urandom_range(LAST_WAY)), IN_DRAW_W'($urandom_range(MAX_DRAW)));
    end else begin
      // decay sweeps the whole store, so keep it rare
      send_word(CMD_DECAY, IN_SET_W'($urandom_range(LAST_SET)),
                IN_WAY_W'($urandom_range(LAST_WAY)), IN_DRAW_W'($urandom_range(MAX_DRAW)));
    end
  endtask

  // Short directed run: field extremes, every command, both leader kinds,
  // PSEL crossing its midpoint, and a dead counter driven to saturation.
  task automatic directed_words();
    // fresh set: way 0
    send_word(CMD_VICTIM, '0, '0, '0);
    // SRRIP leader fill
    send_word(CMD_FILL, '0, '0, IN_DRAW_W'(MAX_DRAW));
    // SR leader hit, PSEL up
    send_word(CMD_HIT, '0, IN_WAY_W'(LAST_WAY), '0);
    // BR leader hit, PSEL down
    send_word(CMD_HIT, IN_SET_W'(LAST_SET), '0, IN_DRAW_W'(MAX_DRAW));
    // PSEL now under midpoint
    send_word(CMD_HIT, IN_SET_W'(LAST_SET), IN_WAY_W'(LAST_WAY), '0);
    // follower on BRRIP, near
    send_word(CMD_FILL, IN_SET_W'(1000), IN_WAY_W'(5), '0);
    // follower on BRRIP, distant
    send_word(CMD_FILL, IN_SET_W'(1000), IN_WAY_W'(6), IN_DRAW_W'(MAX_DRAW));
    // BR leader fill, distant
    send_word(CMD_FILL, IN_SET_W'(LAST_SET), IN_WAY_W'(LAST_WAY), IN_DRAW_W'(MAX_DRAW));
    // BR leader fill, near
    send_word(CMD_FILL, IN_SET_W'(LAST_SET), IN_WAY_W'(LAST_WAY - 1), '0);
    // first way still at 3
    send_word(CMD_VICTIM, IN_SET_W'(1000), IN_WAY_W'(LAST_WAY), IN_DRAW_W'(MAX_DRAW));
    // dead counter to 3, then dead
    repeat (4) send_word(CMD_FILL, IN_SET_W'(5), IN_WAY_W'(3), '0);
    // dead counter back off
    send_word(CMD_HIT, IN_SET_W'(5), IN_WAY_W'(3), '0);
    send_word(CMD_FILL, IN_SET_W'(5), IN_WAY_W'(3), '0);
    // saturated again: inserts at 3
    send_word(CMD_FILL, IN_SET_W'(5), IN_WAY_W'(3), '0);
    // whole-store decay
    send_word(CMD_DECAY, IN_SET_W'(LAST_SET), IN_WAY_W'(LAST_WAY), IN_DRAW_W'(MAX_DRAW));
    // no longer predicted dead
    send_word(CMD_FILL, IN_SET_W'(5), IN_WAY_W'(3), '0);
    // first follower: PSEL unmoved
    send_word(CMD_HIT, IN_SET_W'(LEADER_COUNT), IN_WAY_W'(2), '0);
    // last follower: PSEL unmoved
    send_word(CMD_HIT, IN_SET_W'(BR_BASE - 1), IN_WAY_W'(2), '0);
    send_word(CMD_VICTIM, IN_SET_W'(LAST_SET), '0, '0);
  endtask

  initial begin
    int phase;
    int target;
    sb = new();
    in_if.valid       <= 1'b0;
    in_if.command     <= CMD_VICTIM;
    in_if.set_index   <= '0;
    in_if.way_index   <= '0;
    in_if.random_draw <= '0;

    set_pool[0] = '0;
    set_pool[1] = IN_SET_W'(LEADER_COUNT - 1);
    set_pool[2] = IN_SET_W'(LEADER_COUNT);
    set_pool[3] = IN_SET_W'($urandom_range(BR_BASE - 1, LEADER_COUNT));
    set_pool[4] = IN_SET_W'($urandom_range(BR_BASE - 1, LEADER_COUNT));
    set_pool[5] = IN_SET_W'(BR_BASE - 1);
    set_pool[6] = IN_SET_W'(BR_BASE);
    set_pool[7] = IN_SET_W'(LAST_SET);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    // The clearing pass after reset shows up as ready held low; send_word
    // simply waits it out.

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 83; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 83; end
        default: begin src_idle_pct = 8; sink_stall_pct = 8; end
      endcase
      if (phase == 0) directed_words();
      target = words_sent + WORDS_PER_MIX;
      while (words_sent < target) random_item(phase % 2 == 0);
    end
    in_if.valid <= 1'b0;

    while (sb.pending_outcomes.size() != 0) @(posedge clk);
    // drain period to catch any stray result word
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d words (victim %0d, hit %0d, fill %0d, decay %0d), %0d checked",
             words_sent, sb.words_by_cmd[CMD_VICTIM], sb.words_by_cmd[CMD_HIT],
             sb.words_by_cmd[CMD_FILL], sb.words_by_cmd[CMD_DECAY], sb.checked);
    $display("PSEL ranged %0d..%0d over idle/stall mixes 0/0, 83/0, 0/83 and 8/8",
             sb.psel_lo, sb.psel_hi);
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d results outstanding", sb.pending_outcomes.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
